// ===== rtl/assert_macros.svh =====
// assertion macros shared by the classifier modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define BGC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define BGC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/bgc_pkg.sv =====
// types, constants and the gesture decision function of the button classifier
package bgc_pkg;

	localparam int MAX_PRESSES = 32;
	localparam int COUNT_W     = $clog2(MAX_PRESSES + 1);
	localparam int MASK_W      = 32;
	localparam int TIME_W      = 32;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;

	localparam logic CMD_EVENT = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	localparam logic PIN_PRESSED = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_LONG_PRESS = 2'd1,
		REG_TIMEOUT    = 2'd2
	} reg_idx_t;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd500;
	localparam logic [CFG_W-1:0] TIMEOUT_RST    = 16'd1000;

	typedef enum logic [2:0] {
		GEST_NONE         = 3'd0,
		GEST_SINGLE_SHORT = 3'd1,
		GEST_SINGLE_LONG  = 3'd2,
		GEST_DOUBLE_SHORT = 3'd3,
		GEST_DOUBLE_LONG  = 3'd4,
		GEST_LONG_SHORT   = 3'd5,
		GEST_TRIPLE_LONG  = 3'd6
	} gesture_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] long_press_ms;
		logic [CFG_W-1:0] gesture_timeout_ms;
	} cfg_t;

	// m holds the long flags of the first three presses
	function automatic gesture_t decide(logic [COUNT_W-1:0] n, logic [2:0] m);
		gesture_t g;
		g = GEST_NONE;
		priority if (n == COUNT_W'(1)) begin
			g = m[0] ? GEST_SINGLE_LONG : GEST_SINGLE_SHORT;
		end else if (n == COUNT_W'(2)) begin
			priority if (!m[0] && !m[1]) g = GEST_DOUBLE_SHORT;
			else if (m[0] && m[1])       g = GEST_DOUBLE_LONG;
			else if (m[0] && !m[1])      g = GEST_LONG_SHORT;
			else                         g = GEST_NONE;
		end else if (n == COUNT_W'(3) && (m == 3'b111)) begin
			g = GEST_TRIPLE_LONG;
		end else begin
			g = GEST_NONE;
		end
		return g;
	endfunction

endpackage

// ===== rtl/bgc_cfg_regs.sv =====
// configuration registers of the button classifier
module bgc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [bgc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bgc_pkg::CFG_W-1:0]      cfg_data,
	output bgc_pkg::cfg_t                  cfg
);

	bgc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms        <= bgc_pkg::DEBOUNCE_RST;
			cfg_q.long_press_ms      <= bgc_pkg::LONG_PRESS_RST;
			cfg_q.gesture_timeout_ms <= bgc_pkg::TIMEOUT_RST;
		end else if (cfg_valid) begin
			// writes to an unused index are dropped
			unique case (bgc_pkg::reg_idx_t'(cfg_index))
				bgc_pkg::REG_DEBOUNCE:   cfg_q.debounce_ms        <= cfg_data;
				bgc_pkg::REG_LONG_PRESS: cfg_q.long_press_ms      <= cfg_data;
				bgc_pkg::REG_TIMEOUT:    cfg_q.gesture_timeout_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/bgc_core.sv =====
// gesture state and per-item update logic
`include "assert_macros.svh"

module bgc_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bgc_pkg::cfg_t                cfg,
	input  logic                         fire,
	input  logic                         cmd,
	input  logic                         pin_level,
	input  logic [bgc_pkg::TIME_W-1:0]   now_ms,
	output logic                         has_result,
	output bgc_pkg::gesture_t            gesture
);

	logic                          level_q;
	logic [bgc_pkg::TIME_W-1:0]    last_edge_q;
	logic [bgc_pkg::TIME_W-1:0]    press_start_q;
	logic [bgc_pkg::COUNT_W-1:0]   press_count_q;
	logic [bgc_pkg::MASK_W-1:0]    long_mask_q;

	logic [bgc_pkg::TIME_W-1:0]    since_edge;
	logic [bgc_pkg::TIME_W-1:0]    press_len;
	logic                          bounce;
	logic                          is_long;
	logic                          quiet;
	logic                          can_count;

	// wrapping time differences
	assign since_edge = now_ms - last_edge_q;
	assign press_len  = now_ms - press_start_q;

	assign bounce    = since_edge < bgc_pkg::TIME_W'(cfg.debounce_ms);
	assign is_long   = press_len > bgc_pkg::TIME_W'(cfg.long_press_ms);
	assign quiet     = level_q && !(since_edge < bgc_pkg::TIME_W'(cfg.gesture_timeout_ms));
	assign can_count = press_count_q < bgc_pkg::COUNT_W'(bgc_pkg::MAX_PRESSES);

	assign has_result = (cmd == bgc_pkg::CMD_TICK) && quiet;
	assign gesture    = bgc_pkg::decide(press_count_q, long_mask_q[2:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q       <= 1'b1;
			last_edge_q   <= '0;
			press_start_q <= '0;
			press_count_q <= '0;
			long_mask_q   <= '0;
		end else if (fire) begin
			if (cmd == bgc_pkg::CMD_EVENT) begin
				level_q <= pin_level;
				if (!bounce) begin
					if (pin_level == bgc_pkg::PIN_PRESSED) begin
						press_start_q <= now_ms;
					end else if (can_count) begin
						// the count stays below the mask width here, so every flag fits in the mask
						if (is_long) begin
							long_mask_q <= long_mask_q
								| (bgc_pkg::MASK_W'(1) << press_count_q);
						end
						press_count_q <= press_count_q + 1'b1;
					end
					last_edge_q <= now_ms;
				end
			end else if (quiet) begin
				press_count_q <= '0;
				long_mask_q   <= '0;
			end
		end
	end

	`BGC_ASSERT(a_count_max, press_count_q <= bgc_pkg::COUNT_W'(bgc_pkg::MAX_PRESSES), "press count above max")
	`BGC_ASSERT_NEXT(a_clear_on_decide, fire && has_result, press_count_q == '0 && long_mask_q == '0, "gesture state not cleared")

endmodule

// ===== rtl/button_gesture_classifier.sv =====
// an accepted item is registered in s1 and decided there; its gesture is registered in gesture_q
// throughput: one item per cycle while the result side keeps taking results
// events and non-deciding ticks give no result and never wait on the result side
// reset clears state: level released, times, count and long mask zero
// reset loads debounce 50 ms, long press 500 ms, gesture timeout 1000 ms
`include "assert_macros.svh"

module button_gesture_classifier (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cmd,
	input  logic                           pin_level,
	input  logic [bgc_pkg::TIME_W-1:0]     now_ms,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     gesture,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bgc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bgc_pkg::CFG_W-1:0]      cfg_data
);

	bgc_pkg::cfg_t                 cfg;
	logic                          s1_valid_q;
	logic                          cmd_s1;
	logic                          pin_level_s1;
	logic [bgc_pkg::TIME_W-1:0]    now_ms_s1;
	logic                          out_valid_q;
	logic [2:0]                    gesture_q;
	logic                          has_result;
	bgc_pkg::gesture_t             core_gesture;
	logic                          slot_free;
	logic                          fire;

	assign cfg_ready = 1'b1;

	bgc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bgc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.fire       (fire),
		.cmd        (cmd_s1),
		.pin_level  (pin_level_s1),
		.now_ms     (now_ms_s1),
		.has_result (has_result),
		.gesture    (core_gesture)
	);

	// only an item that yields a result needs room in the output register
	assign slot_free = !out_valid_q || out_ready;
	assign fire      = s1_valid_q && (!has_result || slot_free);
	assign in_ready  = !s1_valid_q || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1       <= cmd;
			pin_level_s1 <= pin_level;
			now_ms_s1    <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= fire && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_result) begin
			gesture_q <= 3'(core_gesture);
		end
	end

	assign out_valid = out_valid_q;
	assign gesture   = gesture_q;

	`BGC_ASSERT_NEXT(a_s1_hold, s1_valid_q && !fire, s1_valid_q && $stable(now_ms_s1) && $stable(cmd_s1), "stalled item lost")
	`BGC_ASSERT(a_ready_low, !in_ready |-> s1_valid_q && has_result && out_valid_q, "ready low without a blocked result")

endmodule
